### src/byte_ring_buffer_with_search_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the byte ring buffer
// Clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_WITH_SEARCH_MACROS_SVH
`define BYTE_RING_BUFFER_WITH_SEARCH_MACROS_SVH

// Same-cycle implication
`define BRBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BRBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/brbs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brbs_pkg
// Word types, codes and controller/datapath handshake types.
// ---------------------------------------------------------------------------
package brbs_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] count;
        logic [7:0]  data_in;
    } brbs_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_out;
        logic        last;
        logic        found;
        logic [11:0] match_offset;
        logic [11:0] bytes_stored;
        logic [11:0] bytes_free;
        logic        is_empty;
        logic        is_full;
    } brbs_out_t;

    localparam logic [2:0] KIND_CLEAR       = 3'd0;
    localparam logic [2:0] KIND_STORE_BEGIN = 3'd1;
    localparam logic [2:0] KIND_STORE_BYTE  = 3'd2;
    localparam logic [2:0] KIND_RETRIEVE    = 3'd3;
    localparam logic [2:0] KIND_VIEW        = 3'd4;
    localparam logic [2:0] KIND_DELETE      = 3'd5;
    localparam logic [2:0] KIND_SEARCH      = 3'd6;
    localparam logic [2:0] KIND_STATUS      = 3'd7;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_NO_STORE = 2'd2;

    localparam logic [1:0] CFG_RING_SLOTS     = 2'd0;
    localparam logic [1:0] CFG_PATTERN_BYTES  = 2'd1;
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam int CFG_DATA_W   = 64;
    localparam int RING_SLOTS_W = 13;
    localparam int PAT_LEN_W    = 4;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_RUN_RD,
        FSM_RUN_OUT,
        FSM_SRCH_CHK,
        FSM_SRCH_SH,
        FSM_RESP
    } brbs_fsm_t;

    typedef struct packed {
        logic load_item;
        logic exec_item;
        logic run_start;
        logic run_next;
        logic mem_rd;
        logic srch_start;
        logic srch_shift;
        logic srch_hit;
        logic srch_miss;
    } brbs_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       run_go;
        logic       srch_go;
        logic       srch_hit;
        logic       srch_end;
        logic       run_last;
    } brbs_stat_t;

endpackage

### src/byte_ring_buffer_with_search.sv
`timescale 1ns / 1ps
`include "byte_ring_buffer_with_search_macros.svh"
// ---------------------------------------------------------------------------
// byte_ring_buffer_with_search
// Byte ring buffer with all-or-nothing stores, run reads and pattern search.
// ---------------------------------------------------------------------------
// The block takes one input word at a time and answers with one result word,
// or one per byte for a retrieve or view run. Clear, store begin, store byte,
// delete, status, refused runs and refused searches pass from the accepting
// state through an execute state to the result state, and the next word is
// taken only once the result is taken. A run reads each byte from memory and
// then offers it in the result register, and ends after its last byte is
// taken. A search walks the stored bytes through the single memory read port,
// reading and shifting each one into a compare window, and stops at the first
// match or at the end of the stored bytes. An output stall holds the block in
// its result state. The ring store has no reset and needs no clearing pass;
// bytes never written are never read. Writing the slot count empties the ring
// and drops an open store.
// ---------------------------------------------------------------------------
module byte_ring_buffer_with_search
    import brbs_pkg::*;
#(
    parameter int RING_DEPTH  = 4096,
    parameter int MAX_RUN     = 64,
    parameter int PATTERN_MAX = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  brbs_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output brbs_out_t             out_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    brbs_cmd_t  cmd;
    brbs_stat_t stat;

    // sequencer: decides which datapath step runs each cycle
    brbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // ring store, points and result word
    brbs_dp #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_RUN     (MAX_RUN),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_data)
    );

    // hold off new words while a result is pending
    `BRBS_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input taken with result pending")
    // an accepted word always leaves the block busy in the cycle after acceptance
    `BRBS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    // fill flags agree with the counts
    `BRBS_ASSERT_NOW(a_empty_count, out_valid && out_data.is_empty, out_data.bytes_stored == 12'd0, "empty but bytes stored")
    `BRBS_ASSERT_NOW(a_full_count, out_valid && out_data.is_full, out_data.bytes_free == 12'd0, "full but bytes free")

endmodule

### src/brbs_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brbs_ctrl
// Sequencer: steps one command at a time through the datapath.
// ---------------------------------------------------------------------------
module brbs_ctrl
    import brbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  brbs_stat_t stat,
    output brbs_cmd_t  cmd
);

    brbs_fsm_t state_reg;
    brbs_fsm_t state_next;
    logic      is_run;

    assign is_run = (stat.kind inside {KIND_RETRIEVE, KIND_VIEW}) && stat.run_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (is_run)
                begin
                    state_next = FSM_RUN_RD;
                end
                else if (stat.kind == KIND_SEARCH && stat.srch_go)
                begin
                    state_next = FSM_SRCH_CHK;
                end
                else
                begin
                    state_next = FSM_RESP;
                end
            end
            FSM_RUN_RD:
            begin
                state_next = FSM_RUN_OUT;
            end
            FSM_RUN_OUT:
            begin
                if (out_ready)
                begin
                    state_next = stat.run_last ? FSM_IDLE : FSM_RUN_RD;
                end
            end
            FSM_SRCH_CHK:
            begin
                if (stat.srch_hit || stat.srch_end)
                begin
                    state_next = FSM_RESP;
                end
                else
                begin
                    state_next = FSM_SRCH_SH;
                end
            end
            FSM_SRCH_SH:
            begin
                state_next = FSM_SRCH_CHK;
            end
            FSM_RESP:
            begin
                if (out_ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            FSM_EXEC:
            begin
                if (is_run)
                begin
                    cmd.run_start = 1'b1;
                end
                else if (stat.kind == KIND_SEARCH && stat.srch_go)
                begin
                    cmd.srch_start = 1'b1;
                end
                else
                begin
                    cmd.exec_item = 1'b1;
                end
            end
            FSM_RUN_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            FSM_RUN_OUT:
            begin
                out_valid    = 1'b1;
                cmd.run_next = out_ready;
            end
            FSM_SRCH_CHK:
            begin
                if (stat.srch_hit)
                begin
                    cmd.srch_hit = 1'b1;
                end
                else if (stat.srch_end)
                begin
                    cmd.srch_miss = 1'b1;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                end
            end
            FSM_SRCH_SH:
            begin
                cmd.srch_shift = 1'b1;
            end
            FSM_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### src/brbs_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brbs_dp
// Ring store, read/write points, run and search counters, result word.
// ---------------------------------------------------------------------------
module brbs_dp
    import brbs_pkg::*;
#(
    parameter int RING_DEPTH  = 4096,
    parameter int MAX_RUN     = 64,
    parameter int PATTERN_MAX = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  brbs_in_t              in_item,
    input  brbs_cmd_t             cmd,
    output brbs_stat_t            stat,
    output brbs_out_t             out_item
);

    localparam int AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int PW   = AW + 1;
    localparam int CMPW = (AW > 12) ? AW : 12;
    localparam int RW   = $clog2(MAX_RUN + 1);
    localparam int LW   = $clog2(PATTERN_MAX + 1);
    localparam int CW   = (PW > RING_SLOTS_W) ? PW : RING_SLOTS_W;

    // configuration
    logic [RING_SLOTS_W-1:0] ring_slots_reg;
    logic [CFG_DATA_W-1:0]   pattern_reg;
    logic [PAT_LEN_W-1:0]    pat_len_reg;

    // control state
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          open_reg, open_next;
    logic [AW-1:0] total_reg, total_next;
    logic [AW-1:0] done_reg, done_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [1:0]    st_reg, st_next;
    logic          found_reg, found_next;
    logic [AW-1:0] off_reg, off_next;
    logic          run_reg, run_next;

    // payload
    brbs_in_t      item_reg;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    rd_data_reg;
    logic [7:0]    win_reg [PATTERN_MAX];
    logic [7:0]    win_next [PATTERN_MAX];
    logic [7:0]    mem [RING_DEPTH];

    logic [CW-1:0] slots_ext;
    logic [PW-1:0] slots;
    logic [AW-1:0] stored;
    logic [AW-1:0] free_cnt;
    logic          empty_flag;
    logic          full_flag;
    logic [RW-1:0] run_n;
    logic [LW-1:0] pat_len;
    logic          win_match;
    logic          mem_we;
    logic [AW-1:0] mem_wa;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b,
                                               input logic [PW-1:0] s);
        logic [PW-1:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= s)
        begin
            sum = sum - s;
        end
        return sum[AW-1:0];
    endfunction

    assign slots_ext = CW'(ring_slots_reg);
    assign slots = (slots_ext < CW'(2))          ? PW'(2) :
                   (slots_ext > CW'(RING_DEPTH)) ? PW'(RING_DEPTH) : PW'(slots_ext);

    assign stored = (wp_reg >= rp_reg) ? (wp_reg - rp_reg)
                                       : AW'(PW'(wp_reg) + slots - PW'(rp_reg));
    assign free_cnt   = AW'(slots - PW'(1) - PW'(stored));
    assign empty_flag = (rp_reg == wp_reg);
    assign full_flag  = (wrap_add(wp_reg, AW'(1), slots) == rp_reg);

    assign run_n = (CMPW'(item_reg.count) > CMPW'(MAX_RUN)) ? RW'(MAX_RUN)
                                                            : RW'(item_reg.count);

    assign pat_len = (pat_len_reg == '0) ? LW'(1) :
                     (32'(pat_len_reg) > 32'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
                                                           : LW'(pat_len_reg);

    // newest byte sits in win_reg[0]; pattern byte j lies len-1-j places back
    always_comb
    begin
        logic [2:0] pidx;
        win_match = 1'b1;
        pidx      = '0;
        for (int m = 0; m < PATTERN_MAX; m++)
        begin
            if (m < int'(pat_len))
            begin
                pidx = 3'(int'(pat_len) - 1 - m);
                if (win_reg[m] != pattern_reg[{pidx, 3'b000} +: 8])
                begin
                    win_match = 1'b0;
                end
            end
        end
    end

    assign stat.kind     = item_reg.kind;
    assign stat.run_go   = (run_n != '0) && (CMPW'(run_n) <= CMPW'(stored));
    assign stat.srch_go  = (stored != '0) && (CMPW'(stored) >= CMPW'(pat_len));
    assign stat.srch_hit = (CMPW'(cnt_reg) >= CMPW'(pat_len)) && win_match;
    assign stat.srch_end = (cnt_reg == stored);
    assign stat.run_last = (rem_reg == RW'(1));

    assign mem_we = cmd.exec_item && (item_reg.kind == KIND_STORE_BYTE) && open_reg;
    assign mem_wa = wrap_add(wp_reg, done_reg, slots);

    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        open_next  = open_reg;
        total_next = total_reg;
        done_next  = done_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        found_next = found_reg;
        off_next   = off_reg;
        run_next   = run_reg;
        addr_next  = addr_reg;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            win_next[k] = win_reg[k];
        end

        if (cmd.exec_item)
        begin
            st_next    = STAT_OK;
            found_next = 1'b0;
            off_next   = '0;
            run_next   = 1'b0;
            case (item_reg.kind)
                KIND_CLEAR:
                begin
                    rp_next    = '0;
                    wp_next    = '0;
                    open_next  = 1'b0;
                    total_next = '0;
                    done_next  = '0;
                end
                KIND_STORE_BEGIN:
                begin
                    open_next  = 1'b0;
                    total_next = '0;
                    done_next  = '0;
                    if (CMPW'(item_reg.count) > CMPW'(free_cnt))
                    begin
                        st_next = STAT_RANGE;
                    end
                    else if (item_reg.count != '0)
                    begin
                        open_next  = 1'b1;
                        total_next = AW'(item_reg.count);
                    end
                end
                KIND_STORE_BYTE:
                begin
                    if (!open_reg)
                    begin
                        st_next = STAT_NO_STORE;
                    end
                    else if ((PW'(done_reg) + PW'(1)) >= PW'(total_reg))
                    begin
                        wp_next    = wrap_add(wp_reg, total_reg, slots);
                        open_next  = 1'b0;
                        total_next = '0;
                        done_next  = '0;
                    end
                    else
                    begin
                        done_next = done_reg + AW'(1);
                    end
                end
                KIND_RETRIEVE, KIND_VIEW:
                begin
                    if (CMPW'(run_n) > CMPW'(stored))
                    begin
                        st_next = STAT_RANGE;
                    end
                end
                KIND_DELETE:
                begin
                    if ((item_reg.count != '0) &&
                        (CMPW'(item_reg.count) <= CMPW'(stored)))
                    begin
                        rp_next = wrap_add(rp_reg, AW'(item_reg.count), slots);
                    end
                    else
                    begin
                        st_next = STAT_RANGE;
                    end
                end
                default:
                begin
                    st_next = STAT_OK;
                end
            endcase
        end

        if (cmd.run_start)
        begin
            st_next    = STAT_OK;
            found_next = 1'b0;
            off_next   = '0;
            run_next   = 1'b1;
            addr_next  = rp_reg;
            rem_next   = run_n;
            if (item_reg.kind == KIND_RETRIEVE)
            begin
                rp_next = wrap_add(rp_reg, AW'(run_n), slots);
            end
        end

        if (cmd.mem_rd)
        begin
            addr_next = wrap_add(addr_reg, AW'(1), slots);
        end

        if (cmd.run_next)
        begin
            rem_next = rem_reg - RW'(1);
        end

        if (cmd.srch_start)
        begin
            st_next    = STAT_OK;
            found_next = 1'b0;
            off_next   = '0;
            run_next   = 1'b0;
            addr_next  = rp_reg;
            cnt_next   = '0;
        end

        if (cmd.srch_shift)
        begin
            win_next[0] = rd_data_reg;
            for (int k = 1; k < PATTERN_MAX; k++)
            begin
                win_next[k] = win_reg[k-1];
            end
            cnt_next = cnt_reg + AW'(1);
        end

        if (cmd.srch_hit)
        begin
            found_next = 1'b1;
            off_next   = cnt_reg - AW'(pat_len);
        end

        if (cmd.srch_miss)
        begin
            found_next = 1'b0;
            off_next   = '0;
        end

        // rewriting the slot count empties the ring
        if (cfg_we && (cfg_addr == CFG_RING_SLOTS))
        begin
            rp_next    = '0;
            wp_next    = '0;
            open_next  = 1'b0;
            total_next = '0;
            done_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_slots_reg <= RING_SLOTS_W'(4096);
            pattern_reg    <= '0;
            pat_len_reg    <= PAT_LEN_W'(1);
            rp_reg         <= '0;
            wp_reg         <= '0;
            open_reg       <= 1'b0;
            total_reg      <= '0;
            done_reg       <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            st_reg         <= STAT_OK;
            found_reg      <= 1'b0;
            off_reg        <= '0;
            run_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_RING_SLOTS:     ring_slots_reg <= cfg_wdata[RING_SLOTS_W-1:0];
                    CFG_PATTERN_BYTES:  pattern_reg    <= cfg_wdata;
                    CFG_PATTERN_LENGTH: pat_len_reg    <= cfg_wdata[PAT_LEN_W-1:0];
                    default:            pat_len_reg    <= pat_len_reg;
                endcase
            end
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            open_reg  <= open_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
            found_reg <= found_next;
            off_reg   <= off_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
        addr_reg <= addr_next;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            win_reg[k] <= win_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= item_reg.data_in;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign out_item.status       = st_reg;
    assign out_item.data_out     = run_reg ? rd_data_reg : 8'd0;
    assign out_item.last         = run_reg ? (rem_reg == RW'(1)) : 1'b1;
    assign out_item.found        = found_reg;
    assign out_item.match_offset = 12'(off_reg);
    assign out_item.bytes_stored = 12'(stored);
    assign out_item.bytes_free   = 12'(free_cnt);
    assign out_item.is_empty     = empty_flag;
    assign out_item.is_full      = full_flag;

endmodule

### tb/tb_byte_ring_buffer_with_search.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_byte_ring_buffer_with_search
// Self-checking bench for the byte ring buffer with run reads and search.
// ---------------------------------------------------------------------------
// A behavioural ring with its own byte store, points and open-store tracking
// predicts every result word; the scoreboard class holds the expected words
// and compares each accepted output word field by field. Stimulus runs a
// directed pass, then mostly well-formed store/read sequences with random
// content, across several slot counts and patterns. Both sides idle at
// random, and two phases hold the output off for a long stretch.
// ---------------------------------------------------------------------------
module tb_byte_ring_buffer_with_search;
    import brbs_pkg::*;

    localparam int RING_DEPTH  = 4096;
    localparam int MAX_RUN     = 64;
    localparam int PATTERN_MAX = 8;
    localparam int CYCLE_LIMIT = 3000000;

    // -----------------------------------------------------------------------
    // Scoreboard: queue of expected result words, mismatch reporting
    // -----------------------------------------------------------------------
    class ring_scoreboard;
        brbs_out_t expected_words[$];
        int        mismatches;

        function void note_result(brbs_out_t w);
            expected_words.push_back(w);
        endfunction

        function void check_word(brbs_out_t got);
            brbs_out_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status || got.data_out !== want.data_out ||
                got.last !== want.last || got.found !== want.found ||
                got.match_offset !== want.match_offset ||
                got.bytes_stored !== want.bytes_stored ||
                got.bytes_free !== want.bytes_free ||
                got.is_empty !== want.is_empty || got.is_full !== want.is_full)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    brbs_in_t         in_data;
    logic             out_valid;
    logic             out_ready;
    brbs_out_t        out_data;
    logic             cfg_we;
    logic [1:0]       cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ring_scoreboard sb;
    int  cycle_count = 0;
    bit  hold_off;      // long output stall requested by the stimulus
    bit  stall_enable;
    event hold_evt;

    // predictor state
    logic [7:0]  ring_bytes [RING_DEPTH];
    int unsigned rd_pt, wr_pt, open_total, open_done;
    bit          open_store;
    int unsigned slots_cfg;
    logic [63:0] pat_cfg;
    int unsigned pat_len_cfg;

    byte_ring_buffer_with_search #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_RUN    (MAX_RUN),
        .PATTERN_MAX(PATTERN_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Predictor helpers
    // -----------------------------------------------------------------------
    function automatic int unsigned eff_slots();
        if (slots_cfg < 2) return 2;
        if (slots_cfg > RING_DEPTH) return RING_DEPTH;
        return slots_cfg;
    endfunction

    function automatic int unsigned eff_pat_len();
        if (pat_len_cfg < 1) return 1;
        if (pat_len_cfg > PATTERN_MAX) return PATTERN_MAX;
        return pat_len_cfg;
    endfunction

    function automatic int unsigned held_bytes();
        return (wr_pt + eff_slots() - rd_pt) % eff_slots();
    endfunction

    function automatic int unsigned free_bytes();
        return (rd_pt + eff_slots() - 1 - wr_pt) % eff_slots();
    endfunction

    function automatic brbs_out_t fill_word(logic [1:0] st, logic [7:0] d, bit lst,
                                            bit fnd, int unsigned off);
        brbs_out_t w;
        w.status       = st;
        w.data_out     = d;
        w.last         = lst;
        w.found        = fnd;
        w.match_offset = off[11:0];
        w.bytes_stored = 12'(held_bytes());
        w.bytes_free   = 12'(free_bytes());
        w.is_empty     = (rd_pt == wr_pt);
        w.is_full      = ((wr_pt + 1) % eff_slots() == rd_pt);
        return w;
    endfunction

    function automatic void empty_ring();
        rd_pt = 0;
        wr_pt = 0;
        open_store = 0;
        open_total = 0;
        open_done = 0;
    endfunction

    // Apply one accepted input word to the predicted ring; queue its results.
    function automatic void predict_ring(brbs_in_t w);
        logic [1:0]  st;
        bit          fnd;
        int unsigned off, n, base, len, sz;
        bit          ok;
        st = STAT_OK;
        fnd = 0;
        off = 0;
        case (w.kind)
            KIND_CLEAR: empty_ring();
            KIND_STORE_BEGIN:
            begin
                open_store = 0;
                open_done = 0;
                open_total = 0;
                if (32'(w.count) > free_bytes()) st = STAT_RANGE;
                else if (w.count != 12'd0)
                begin
                    open_store = 1;
                    open_total = 32'(w.count);
                end
            end
            KIND_STORE_BYTE:
            begin
                if (!open_store) st = STAT_NO_STORE;
                else
                begin
                    ring_bytes[(wr_pt + open_done) % eff_slots()] = w.data_in;
                    open_done++;
                    if (open_done >= open_total)
                    begin
                        wr_pt = (wr_pt + open_total) % eff_slots();
                        open_store = 0;
                        open_total = 0;
                        open_done = 0;
                    end
                end
            end
            KIND_RETRIEVE, KIND_VIEW:
            begin
                n = (32'(w.count) > MAX_RUN) ? MAX_RUN : 32'(w.count);
                base = rd_pt;
                if (n > held_bytes()) st = STAT_RANGE;
                else if (n > 0)
                begin
                    if (w.kind == KIND_RETRIEVE) rd_pt = (rd_pt + n) % eff_slots();
                    for (int i = 0; i < n; i++)
                        sb.note_result(fill_word(STAT_OK,
                            ring_bytes[(base + i) % eff_slots()], i + 1 == n, 0, 0));
                    return;
                end
            end
            KIND_DELETE:
            begin
                if (w.count != 12'd0 && 32'(w.count) <= held_bytes())
                    rd_pt = (rd_pt + 32'(w.count)) % eff_slots();
                else
                    st = STAT_RANGE;
            end
            KIND_SEARCH:
            begin
                len = eff_pat_len();
                sz = held_bytes();
                if (sz > 0 && sz >= len)
                    for (int i = 0; i + len <= sz && !fnd; i++)
                    begin
                        ok = 1;
                        for (int j = 0; j < len; j++)
                            if (ring_bytes[(rd_pt + i + j) % eff_slots()] !==
                                pat_cfg[8*j +: 8])
                                ok = 0;
                        if (ok)
                        begin
                            fnd = 1;
                            off = i;
                        end
                    end
            end
            default: ;
        endcase
        sb.note_result(fill_word(st, 8'd0, 1, fnd, off));
    endfunction

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------
    // Offer one word, hold it until accepted, then note it with the predictor.
    task automatic send_word(logic [2:0] k, int unsigned cnt, logic [7:0] d);
        brbs_in_t w;
        w.kind = k;
        w.count = cnt[11:0];
        w.data_in = d;
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        predict_ring(w);
    endtask

    // Lower valid after a word if the burst ends, and idle a random gap.
    task automatic maybe_gap();
        int g;
        if ($urandom_range(0, 3) == 0)
        begin
            g = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic put(logic [2:0] k, int unsigned cnt, logic [7:0] d);
        send_word(k, cnt, d);
        maybe_gap();
    endtask

    // Wait until every expected word has arrived plus the worst search time.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (2 * RING_DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RING_SLOTS)
        begin
            slots_cfg = 32'(val[12:0]);
            empty_ring();
        end
        else if (idx == CFG_PATTERN_BYTES) pat_cfg = val;
        else pat_len_cfg = 32'(val[3:0]);
    endtask

    // Complete store of n random bytes, sometimes borrowing pattern bytes.
    task automatic store_run(int unsigned n);
        put(KIND_STORE_BEGIN, n, 8'($urandom));
        for (int i = 0; i < n; i++)
            put(KIND_STORE_BYTE, $urandom,
                ($urandom_range(0, 2) == 0) ? pat_cfg[8*(i % eff_pat_len()) +: 8]
                                            : 8'($urandom_range(0, 3)));
    endtask

    // -----------------------------------------------------------------------
    // Receiver: random stall pattern, long hold-off when asked
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if (stall_enable)
            out_ready <= ($urandom_range(0, 9) > 3);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(out_data);
    end

    // Hold the output off for a long stretch whenever requested.
    initial
    begin
        hold_off = 0;
        forever
        begin
            @(hold_evt);
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
        end
    end

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        int unsigned sz, n;
        int k;
        sb = new();
        stall_enable = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_RING_SLOTS;
        cfg_wdata = '0;
        slots_cfg = RING_DEPTH;
        pat_cfg = '0;
        pat_len_cfg = 1;
        empty_ring();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small ring, every kind and refusal
        write_reg(CFG_RING_SLOTS, 64'd8);
        write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0000_BBAA);
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        put(KIND_STORE_BYTE, 0, 8'hFF);        // no open store
        put(KIND_STORE_BEGIN, 8, 8'd0);        // too large for 7 free
        put(KIND_STORE_BEGIN, 0, 8'd0);        // zero count
        put(KIND_RETRIEVE, 1, 8'd0);           // more than stored
        put(KIND_DELETE, 0, 8'd0);             // zero delete
        put(KIND_SEARCH, 0, 8'd0);             // nothing stored
        put(KIND_STORE_BEGIN, 3, 8'd0);
        put(KIND_STORE_BYTE, 0, 8'h11);
        put(KIND_STORE_BEGIN, 7, 8'd0);        // abandons the open store
        put(KIND_STORE_BYTE, 4095, 8'h00);
        put(KIND_STORE_BYTE, 0, 8'hFF);
        put(KIND_STORE_BYTE, 0, 8'hAA);
        put(KIND_STORE_BYTE, 0, 8'hBB);
        put(KIND_STORE_BYTE, 0, 8'h55);
        put(KIND_STORE_BYTE, 0, 8'hAA);
        put(KIND_STORE_BYTE, 0, 8'h01);        // ring now full
        put(KIND_STATUS, 4095, 8'hFF);
        put(KIND_SEARCH, 0, 8'd0);
        put(KIND_VIEW, 4095, 8'd0);            // run capped, longer than stored
        put(KIND_VIEW, 0, 8'd0);
        put(KIND_RETRIEVE, 3, 8'd0);
        put(KIND_DELETE, 9, 8'd0);
        put(KIND_DELETE, 2, 8'd0);
        put(KIND_CLEAR, 0, 8'd0);
        drain();

        // Random phases over several settings, extremes included
        stall_enable = 1;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: sz = 2;
                1: sz = RING_DEPTH;
                2: sz = 0;        // below range, acts as 2
                3: sz = 8191;     // above range
                default: sz = $urandom_range(3, 200);
            endcase
            write_reg(CFG_RING_SLOTS, 64'(sz));
            write_reg(CFG_PATTERN_BYTES, {$urandom, $urandom});
            write_reg(CFG_PATTERN_LENGTH,
                      (phase == 1) ? 64'd15 : 64'($urandom_range(0, 8)));
            if (phase == 3) write_reg(CFG_PATTERN_BYTES, '1);
            // long receiver stall while the sender keeps offering words
            if (phase == 1 || phase == 4) -> hold_evt;
            for (int i = 0; i < 20; i++)
            begin
                k = $urandom_range(0, 9);
                if (k < 5)
                begin
                    n = $urandom_range(0, (free_bytes() < 12) ? free_bytes() : 12);
                    if (n == 0) n = 1;
                    store_run(n);
                end
                else if (k < 8)
                    put(($urandom_range(0, 1)) ? KIND_RETRIEVE : KIND_VIEW,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 10), 8'd0);
                else if (k == 8)
                    put(KIND_SEARCH, $urandom, 8'($urandom));
                else
                    // noise: any kind, any field values; clear and status too
                    put(3'($urandom_range(0, 7)),
                        ($urandom_range(0, 1)) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, 8),
                        8'($urandom));
            end
            drain();
        end

        if (sb.expected_words.size() == 0 && sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/brbs_pkg.sv
src/brbs_ctrl.sv
src/brbs_dp.sv
src/byte_ring_buffer_with_search.sv
tb/tb_byte_ring_buffer_with_search.sv
